>>> hw/rtl/gcbi_pkg.sv
package gcbi_pkg;

  localparam int MAX_BANDS_DEF    = 8;
  localparam int MAX_GRID_DIM_DEF = 32;
  localparam int COEF_WIDTH_DEF   = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_SPAN_WIDTH  = 3'd2,
    REG_SPAN_HEIGHT = 3'd3,
    REG_GRID_COLS   = 3'd4,
    REG_GRID_ROWS   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic               action;
    logic [2:0]         band;
    logic [4:0]         node_row;
    logic [4:0]         node_col;
    logic signed [31:0] load_a;
    logic signed [31:0] load_b;
    logic signed [31:0] load_c;
    logic [15:0]        point_x;
    logic [15:0]        point_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] out_a;
    logic signed [31:0] out_b;
    logic signed [31:0] out_c;
    logic               outside;
  } out_word_t;

  // Item state that travels down the mapping pipeline.
  typedef struct packed {
    logic               valid;
    logic               query;
    logic               ok;
    logic [2:0]         band;
    logic [4:0]         node_row;
    logic [4:0]         node_col;
    logic signed [31:0] load_a;
    logic signed [31:0] load_b;
    logic signed [31:0] load_c;
  } map_item_t;

endpackage

>>> hw/rtl/gcbi_if.sv
interface gcbi_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/gcbi_map.sv
module gcbi_map #(
  parameter int MAX_BANDS = gcbi_pkg::MAX_BANDS_DEF,
  parameter int MAX_GRID_DIM = gcbi_pkg::MAX_GRID_DIM_DEF,
  localparam int IW = $clog2(MAX_GRID_DIM),
  localparam int QW = IW + 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 item_valid,
  input  gcbi_pkg::in_word_t   item_word,
  input  logic [15:0]          org_x,
  input  logic [15:0]          org_y,
  input  logic [16:0]          sp_x,
  input  logic [16:0]          sp_y,
  input  logic [IW-1:0]        sm1_x,
  input  logic [IW-1:0]        sm1_y,
  output gcbi_pkg::map_item_t  mapped,
  output logic [QW-1:0]        quo_x,
  output logic [QW-1:0]        quo_y
);
  import gcbi_pkg::*;

  localparam int PW = IW + 16;

  typedef struct packed {
    map_item_t   it;
    logic [15:0] off_x;
    logic [15:0] off_y;
  } s0_t;

  typedef struct packed {
    map_item_t     it;
    logic [PW-1:0] prod_x;
    logic [PW-1:0] prod_y;
  } s1_t;

  typedef struct packed {
    map_item_t     it;
    logic [16:0]   rem_x;
    logic [16:0]   rem_y;
    logic [QW-1:0] rq_x;
    logic [QW-1:0] rq_y;
  } dv_t;

  s0_t s0, s0_next;
  s1_t s1, s1_next;
  dv_t dv0;
  dv_t dv_st [QW];

  // One restoring division step: bring down the next dividend bit, subtract
  // the divisor when it fits and shift the quotient bit in at the bottom.
  function automatic logic [16+QW:0] div_step(input logic [16:0] rem,
                                              input logic [QW-1:0] rq,
                                              input logic [16:0] d);
    logic [17:0] r2;
    logic        ge;
    r2 = {rem, rq[QW-1]};
    ge = (r2 >= {1'b0, d});
    return {(ge ? 17'(r2 - {1'b0, d}) : r2[16:0]), rq[QW-2:0], ge};
  endfunction

  always_comb begin
    logic band_ok, in_x, in_y, row_ok, col_ok;
    band_ok = ({2'b00, item_word.band} < 5'(MAX_BANDS));
    in_x = (item_word.point_x >= org_x) &&
           ({1'b0, item_word.point_x - org_x} <= sp_x - 17'd1);
    in_y = (item_word.point_y >= org_y) &&
           ({1'b0, item_word.point_y - org_y} <= sp_y - 17'd1);
    row_ok = (9'(item_word.node_row) < 9'(MAX_GRID_DIM));
    col_ok = (9'(item_word.node_col) < 9'(MAX_GRID_DIM));
    s0_next.it.valid    = item_valid;
    s0_next.it.query    = (item_word.action == ACT_QUERY);
    s0_next.it.ok       = s0_next.it.query ? (band_ok && in_x && in_y)
                                           : (band_ok && row_ok && col_ok);
    s0_next.it.band     = item_word.band;
    s0_next.it.node_row = item_word.node_row;
    s0_next.it.node_col = item_word.node_col;
    s0_next.it.load_a   = item_word.load_a;
    s0_next.it.load_b   = item_word.load_b;
    s0_next.it.load_c   = item_word.load_c;
    s0_next.off_x       = item_word.point_x - org_x;
    s0_next.off_y       = item_word.point_y - org_y;
  end

  always_comb begin
    s1_next.it     = s0.it;
    s1_next.prod_x = PW'(s0.off_x) * PW'(sm1_x);
    s1_next.prod_y = PW'(s0.off_y) * PW'(sm1_y);
  end

  // The quotient is known to stay below 2^QW, so the top of the dividend
  // already sits below the divisor and seeds the remainder.
  always_comb begin
    dv0.it    = s1.it;
    dv0.rem_x = 17'(s1.prod_x[PW-1:IW]);
    dv0.rem_y = 17'(s1.prod_y[PW-1:IW]);
    dv0.rq_x  = {s1.prod_x[IW-1:0], 16'd0};
    dv0.rq_y  = {s1.prod_y[IW-1:0], 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.it.valid <= 1'b0;
      s1.it.valid <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
      s1 <= s1_next;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    dv_t src, nxt;
    if (k == 0) begin : g_first
      assign src = dv0;
    end else begin : g_next
      assign src = dv_st[k-1];
    end
    always_comb begin
      nxt = src;
      {nxt.rem_x, nxt.rq_x} = div_step(src.rem_x, src.rq_x, sp_x);
      {nxt.rem_y, nxt.rq_y} = div_step(src.rem_y, src.rq_y, sp_y);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_st[k].it.valid <= 1'b0;
      end else if (en) begin
        dv_st[k] <= nxt;
      end
    end
  end

  assign mapped = dv_st[QW-1].it;
  assign quo_x  = dv_st[QW-1].rq_x;
  assign quo_y  = dv_st[QW-1].rq_y;

endmodule

>>> hw/rtl/gcbi_bank.sv
module gcbi_bank #(
  parameter int AW = 10,
  parameter int DW = 96
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> hw/rtl/gcbi_lerp.sv
module gcbi_lerp (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] v0,
  input  logic signed [31:0] v1,
  input  logic [15:0]        t,
  output logic signed [31:0] r
);
  logic signed [32:0] diff;
  logic signed [31:0] v0_1, v0_2;
  logic [15:0]        t1;
  logic signed [49:0] prod;

  // Difference, product and a floored shift-add, one register apart.
  always_ff @(posedge clk) begin
    if (en) begin
      diff <= 33'(v1) - 33'(v0);
      v0_1 <= v0;
      t1   <= t;
      prod <= diff * $signed({1'b0, t1});
      v0_2 <= v0_1;
      r    <= v0_2 + 32'(prod >>> 16);
    end
  end
endmodule

>>> hw/rtl/grid_coefficient_bilinear_interp.sv
// Throughput: one word per cycle while the result buffer is not full; the
// one-bit-per-stage grid position divider and the four-bank node store keep
// every stage busy with a fresh word.
// Reset clears the configuration registers to their defaults and empties the
// pipeline and result buffer; the coefficient stores hold no reset value.
module grid_coefficient_bilinear_interp #(
  parameter int MAX_BANDS    = gcbi_pkg::MAX_BANDS_DEF,
  parameter int MAX_GRID_DIM = gcbi_pkg::MAX_GRID_DIM_DEF,
  parameter int COEF_WIDTH   = gcbi_pkg::COEF_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gcbi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [gcbi_pkg::CFG_DATA_W-1:0]  cfg_data,
  gcbi_if.sink                            item,
  gcbi_if.source                          result
);
  import gcbi_pkg::*;

  localparam int IW = $clog2(MAX_GRID_DIM);
  localparam int QW = IW + 16;
  // Nodes are banked by row and column parity so the four neighbours of a
  // cell always land in four different banks, one read port each.
  localparam int HW = (IW > 1) ? IW - 1 : 1;
  localparam int BW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int AW = BW + 2 * HW;
  localparam int SW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
  localparam int DW = 3 * SW;

  typedef struct packed {
    logic res;
    logic outside;
  } ctl_t;

  // Configuration registers.
  logic [15:0] origin_x, origin_y;
  logic [16:0] span_width, span_height;
  logic [5:0]  grid_cols, grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= 16'd0;
      origin_y    <= 16'd0;
      span_width  <= 17'd1;
      span_height <= 17'd1;
      grid_cols   <= 6'd2;
      grid_rows   <= 6'd2;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORIGIN_X:    origin_x    <= cfg_data[15:0];
        REG_ORIGIN_Y:    origin_y    <= cfg_data[15:0];
        REG_SPAN_WIDTH:  span_width  <= cfg_data[16:0];
        REG_SPAN_HEIGHT: span_height <= cfg_data[16:0];
        REG_GRID_COLS:   grid_cols   <= cfg_data[5:0];
        REG_GRID_ROWS:   grid_rows   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Effective span and grid size. A zero span acts as one, and the grid size
  // is clamped into the range the store can hold.
  logic [16:0]   sp_x, sp_y;
  logic [8:0]    cols_eff, rows_eff;
  logic [IW-1:0] sm1_x, sm1_y;

  assign sp_x = (span_width == 17'd0) ? 17'd1 : span_width;
  assign sp_y = (span_height == 17'd0) ? 17'd1 : span_height;

  always_comb begin
    if (grid_cols < 6'd2) begin
      cols_eff = 9'd2;
    end else if (9'(grid_cols) > 9'(MAX_GRID_DIM)) begin
      cols_eff = 9'(MAX_GRID_DIM);
    end else begin
      cols_eff = 9'(grid_cols);
    end
    if (grid_rows < 6'd2) begin
      rows_eff = 9'd2;
    end else if (9'(grid_rows) > 9'(MAX_GRID_DIM)) begin
      rows_eff = 9'(MAX_GRID_DIM);
    end else begin
      rows_eff = 9'(grid_rows);
    end
  end

  assign sm1_x = IW'(cols_eff - 9'd1);
  assign sm1_y = IW'(rows_eff - 9'd1);

  // The whole pipeline advances together; it only stops when the two-word
  // result buffer is full, so a single waiting result does not block intake.
  logic [1:0] fifo_cnt;
  logic       en;

  assign en         = (fifo_cnt != 2'd2);
  assign item.ready = en;

  // Mapping: inside test, offset times (size - 1), then the pipelined divider.
  map_item_t     mapped;
  logic [QW-1:0] quo_x, quo_y;

  gcbi_map #(
    .MAX_BANDS   (MAX_BANDS),
    .MAX_GRID_DIM(MAX_GRID_DIM)
  ) u_map (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item_valid(item.valid),
    .item_word (item.data),
    .org_x     (origin_x),
    .org_y     (origin_y),
    .sp_x      (sp_x),
    .sp_y      (sp_y),
    .sm1_x     (sm1_x),
    .sm1_y     (sm1_y),
    .mapped    (mapped),
    .quo_x     (quo_x),
    .quo_y     (quo_y)
  );

  // Node index with the clamp that keeps the +1 neighbour inside the grid.
  logic [IW-1:0] xi_raw, yi_raw, xi, yi, xi_p1, yi_p1, row_iw, col_iw;
  logic [IW-1:0] lim_x, lim_y;
  logic [HW-1:0] row_half [2];
  logic [HW-1:0] col_half [2];

  assign xi_raw = quo_x[QW-1:16];
  assign yi_raw = quo_y[QW-1:16];
  assign lim_x  = sm1_x - IW'(1);
  assign lim_y  = sm1_y - IW'(1);
  assign xi     = (xi_raw > lim_x) ? lim_x : xi_raw;
  assign yi     = (yi_raw > lim_y) ? lim_y : yi_raw;
  assign xi_p1  = xi + IW'(1);
  assign yi_p1  = yi + IW'(1);

  // The even-parity bank holds whichever of index and index + 1 is even.
  assign row_half[0] = HW'(yi_p1 >> 1);
  assign row_half[1] = HW'(yi >> 1);
  assign col_half[0] = HW'(xi_p1 >> 1);
  assign col_half[1] = HW'(xi >> 1);

  assign row_iw = IW'(mapped.node_row);
  assign col_iw = IW'(mapped.node_col);

  // Loads write in the same stage where queries read, which keeps loads and
  // queries in their arrival order.
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rd [4];

  assign waddr = {BW'(mapped.band), HW'(row_iw >> 1), HW'(col_iw >> 1)};
  assign wdata = {mapped.load_a[SW-1:0], mapped.load_b[SW-1:0], mapped.load_c[SW-1:0]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int RP = b / 2;
    localparam int CP = b % 2;
    logic          we;
    logic [AW-1:0] raddr;

    assign we = en && mapped.valid && !mapped.query && mapped.ok &&
                ({row_iw[0], col_iw[0]} == 2'(b));
    assign raddr = {BW'(mapped.band), row_half[RP], col_half[CP]};

    gcbi_bank #(
      .AW(AW),
      .DW(DW)
    ) u_bank (
      .clk  (clk),
      .en   (en),
      .we   (we),
      .waddr(waddr),
      .wdata(wdata),
      .raddr(raddr),
      .rdata(rd[b])
    );
  end

  // Bank stage control, alongside the registered bank read.
  ctl_t        bk_ctl;
  logic [15:0] bk_fx, bk_fy;
  logic [1:0]  bk_par;

  always_ff @(posedge clk) begin
    if (rst) begin
      bk_ctl.res <= 1'b0;
    end else if (en) begin
      bk_ctl.res <= mapped.valid && mapped.query;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bk_ctl.outside <= !mapped.ok;
      bk_fx          <= quo_x[15:0];
      bk_fy          <= quo_y[15:0];
      bk_par         <= {yi[0], xi[0]};
    end
  end

  // Route banks to the four corners: corner (row r, col c) sits in the bank
  // whose parity is the cell's parity flipped by r and c.
  logic signed [31:0] corner [4][3];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    logic [DW-1:0] cd;
    assign cd = rd[{bk_par[1] ^ c[1], bk_par[0] ^ c[0]}];
    for (genvar k = 0; k < 3; k++) begin : g_coef
      assign corner[c][k] = 32'($signed(cd[DW-1-k*SW -: SW]));
    end
  end

  // Interpolate along x on the upper and lower row, then along y.
  logic signed [31:0] hx [3][2];
  logic signed [31:0] hy [3];
  ctl_t               ctl_d [6];
  logic [15:0]        fy_d [3];

  for (genvar k = 0; k < 3; k++) begin : g_lerp
    for (genvar r = 0; r < 2; r++) begin : g_row
      gcbi_lerp u_lerp_x (
        .clk(clk),
        .en (en),
        .v0 (corner[2*r][k]),
        .v1 (corner[2*r+1][k]),
        .t  (bk_fx),
        .r  (hx[k][r])
      );
    end
    gcbi_lerp u_lerp_y (
      .clk(clk),
      .en (en),
      .v0 (hx[k][0]),
      .v1 (hx[k][1]),
      .t  (fy_d[2]),
      .r  (hy[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        ctl_d[i].res <= 1'b0;
      end
    end else if (en) begin
      ctl_d[0].res <= bk_ctl.res;
      for (int i = 1; i < 6; i++) begin
        ctl_d[i].res <= ctl_d[i-1].res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_d[0].outside <= bk_ctl.outside;
      fy_d[0]          <= bk_fy;
      for (int i = 1; i < 6; i++) begin
        ctl_d[i].outside <= ctl_d[i-1].outside;
      end
      for (int i = 1; i < 3; i++) begin
        fy_d[i] <= fy_d[i-1];
      end
    end
  end

  // Result word; a point outside the span, or a band beyond the store, gives zero coefficients.
  out_word_t new_word;
  logic      push, pop;

  always_comb begin
    new_word.outside = ctl_d[5].outside;
    new_word.out_a   = ctl_d[5].outside ? 32'sd0 : hy[0];
    new_word.out_b   = ctl_d[5].outside ? 32'sd0 : hy[1];
    new_word.out_c   = ctl_d[5].outside ? 32'sd0 : hy[2];
  end

  // Two-word result buffer that decouples the pipeline from the consumer.
  out_word_t slot [2];

  assign push         = en && ctl_d[5].res;
  assign pop          = result.valid && result.ready;
  assign result.valid = (fifo_cnt != 2'd0);
  assign result.data  = slot[0];

  always_ff @(posedge clk) begin
    if (push && ((fifo_cnt == 2'd0) || ((fifo_cnt == 2'd1) && pop))) begin
      slot[0] <= new_word;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
    if (push && (fifo_cnt == 2'd1) && !pop) begin
      slot[1] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_cnt <= 2'd0;
    end else begin
      fifo_cnt <= fifo_cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> dv/testbench.sv
module testbench;
  import gcbi_pkg::*;

  // Sizes of the node store as the block is built by default.
  localparam int NBANDS = MAX_BANDS_DEF;
  localparam int GDIM   = MAX_GRID_DIM_DEF;
  localparam int NNODES = NBANDS * GDIM * GDIM;
  // Settle for longer than a query takes to come out.
  localparam int SETTLE_CYCLES = 40;
  // No correct run goes this long without moving a word on either side.
  localparam int STALL_LIMIT = 4000;

  // One row of the directed table. When typed is set, the expected result is
  // the one written in the row; otherwise the predictor supplies it.
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  // One register setting for a random phase.
  typedef struct {
    logic [15:0] ox;
    logic [15:0] oy;
    logic [16:0] sw;
    logic [16:0] sh;
    logic [5:0]  gc;
    logic [5:0]  gr;
  } grid_cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  gcbi_if #(.word_t(in_word_t))  item_ch ();
  gcbi_if #(.word_t(out_word_t)) result_ch ();

  grid_coefficient_bilinear_interp dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always #1 clk = ~clk;

  // The predictor's own copy of the registers and the three node stores.
  logic [15:0] cur_ox, cur_oy;
  logic [16:0] cur_sw, cur_sh;
  logic [5:0]  cur_gc, cur_gr;
  logic signed [31:0] node_a [NNODES];
  logic signed [31:0] node_b [NNODES];
  logic signed [31:0] node_c [NNODES];
  bit node_loaded [NNODES];

  // Interpolated results still owed by the block, oldest first.
  out_word_t coef_due [$];
  int errors = 0;
  bit quiet = 1'b0;      // end of the run: no idling on either side
  int idle_cycles = 0;   // cycles in a row with no word moved

  function automatic int node_addr(input int band, input int row, input int col);
    return (band * GDIM + row) * GDIM + col;
  endfunction

  function automatic longint unsigned eff_dim(input logic [5:0] sz);
    if (sz < 2) return 2;
    if (sz > GDIM) return GDIM;
    return 64'(sz);
  endfunction

  // Maps one image coordinate into grid space: node index plus 16-bit fraction.
  // The index is clamped so that the +1 neighbour is still a grid node.
  function automatic bit grid_axis(input logic [15:0] p, input logic [15:0] org,
                                   input logic [16:0] span, input logic [5:0] sz,
                                   output int idx, output longint frac);
    longint unsigned sp, es, off, pos;
    sp = (span == 0) ? 64'd1 : 64'(span);
    es = eff_dim(sz);
    idx = 0;
    frac = 0;
    if (p < org) return 1'b0;
    off = longint'(p) - longint'(org);
    if (off > sp - 1) return 1'b0;
    pos = ((off * (es - 1)) << 16) / sp;
    idx = int'(pos >> 16);
    frac = longint'(pos & 64'hFFFF);
    if (idx > es - 2) idx = int'(es - 2);
    return 1'b1;
  endfunction

  // Finds the four neighbouring nodes of a query; returns 0 when it is outside or its band is beyond the store.
  function automatic bit query_nodes(input in_word_t w, output int adr [4],
                                     output longint xt, output longint yt);
    int xi, yi;
    bit inx, iny;
    inx = grid_axis(w.point_x, cur_ox, cur_sw, cur_gc, xi, xt);
    iny = grid_axis(w.point_y, cur_oy, cur_sh, cur_gr, yi, yt);
    adr[0] = node_addr(int'(w.band), yi, xi);
    adr[1] = adr[0] + 1;
    adr[2] = adr[0] + GDIM;
    adr[3] = adr[2] + 1;
    return inx && iny && (w.band < NBANDS);
  endfunction

  // One linear step with the product floored toward minus infinity.
  function automatic longint lerp16(input longint v0, input longint v1, input longint t);
    return v0 + (((v1 - v0) * t) >>> 16);
  endfunction

  function automatic logic signed [31:0] blend(input longint v00, input longint v01,
                                              input longint v10, input longint v11,
                                              input longint xt, input longint yt);
    longint top, bot;
    top = lerp16(v00, v01, xt);
    bot = lerp16(v10, v11, xt);
    return 32'(lerp16(top, bot, yt));
  endfunction

  // Applies one accepted word to the predictor; a query owes one result.
  task automatic predict_word(input in_word_t w, input bit typed, input out_word_t want);
    int adr [4];
    longint xt, yt;
    int a;
    out_word_t r;
    if (w.action == ACT_LOAD) begin
      if (w.band < NBANDS) begin
        a = node_addr(int'(w.band), int'(w.node_row), int'(w.node_col));
        node_a[a] = w.load_a;
        node_b[a] = w.load_b;
        node_c[a] = w.load_c;
        node_loaded[a] = 1'b1;
      end
      return;
    end
    r = '0;
    r.outside = 1'b1;
    if (query_nodes(w, adr, xt, yt)) begin
      r.out_a = blend(node_a[adr[0]], node_a[adr[1]], node_a[adr[2]], node_a[adr[3]], xt, yt);
      r.out_b = blend(node_b[adr[0]], node_b[adr[1]], node_b[adr[2]], node_b[adr[3]], xt, yt);
      r.out_c = blend(node_c[adr[0]], node_c[adr[1]], node_c[adr[2]], node_c[adr[3]], xt, yt);
      r.outside = 1'b0;
    end
    coef_due.push_back(typed ? want : r);
  endtask

  // Random sender gaps, none at the end of the run.
  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Offers one word and holds it until the block takes it.
  task automatic send_word(input in_word_t w, input bit typed = 1'b0,
                           input out_word_t want = '0);
    maybe_gap();
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    do @(posedge clk); while (!item_ch.ready);
    predict_word(w, typed, want);
  endtask

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return 32'sh0;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t load_word(input int band, input int row, input int col,
                                         input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c);
    in_word_t w;
    w = '0;
    w.action   = ACT_LOAD;
    w.band     = 3'(band);
    w.node_row = 5'(row);
    w.node_col = 5'(col);
    w.load_a   = a;
    w.load_b   = b;
    w.load_c   = c;
    w.point_x  = 16'($urandom);
    w.point_y  = 16'($urandom);
    return w;
  endfunction

  function automatic in_word_t query_word(input int band, input int px, input int py);
    in_word_t w;
    w.action   = ACT_QUERY;
    w.band     = 3'(band);
    w.node_row = 5'($urandom);
    w.node_col = 5'($urandom);
    w.load_a   = $urandom;
    w.load_b   = $urandom;
    w.load_c   = $urandom;
    w.point_x  = 16'(px);
    w.point_y  = 16'(py);
    return w;
  endfunction

  // Sends a query, first loading any neighbour node that was never written so
  // that the block is never asked for an undefined node.
  task automatic send_query(input in_word_t w);
    int adr [4];
    longint xt, yt;
    int band, row, col;
    if (query_nodes(w, adr, xt, yt)) begin
      foreach (adr[k]) begin
        if (!node_loaded[adr[k]]) begin
          band = adr[k] / (GDIM * GDIM);
          row  = (adr[k] / GDIM) % GDIM;
          col  = adr[k] % GDIM;
          send_word(load_word(band, row, col, rand_coef(), rand_coef(), rand_coef()));
        end
      end
    end
    send_word(w);
  endtask

  // Registers change only with the block idle: every result in, then a pause
  // for loads that may still be in flight.
  task automatic write_grid_cfg(input grid_cfg_t g);
    item_ch.valid <= 1'b0;
    while (coef_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;    cfg_data <= CFG_DATA_W'(g.ox); @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;    cfg_data <= CFG_DATA_W'(g.oy); @(posedge clk);
    cfg_index <= REG_SPAN_WIDTH;  cfg_data <= CFG_DATA_W'(g.sw); @(posedge clk);
    cfg_index <= REG_SPAN_HEIGHT; cfg_data <= CFG_DATA_W'(g.sh); @(posedge clk);
    cfg_index <= REG_GRID_COLS;   cfg_data <= CFG_DATA_W'(g.gc); @(posedge clk);
    cfg_index <= REG_GRID_ROWS;   cfg_data <= CFG_DATA_W'(g.gr); @(posedge clk);
    cfg_we <= 1'b0;
    cur_ox = g.ox; cur_oy = g.oy;
    cur_sw = g.sw; cur_sh = g.sh;
    cur_gc = g.gc; cur_gr = g.gr;
  endtask

  // A random phase: mostly queries inside the span with random content, some
  // loads of nodes in and around the grid in use, and some points anywhere.
  task automatic run_phase(input int count);
    int px, py, lim_r, lim_c;
    longint unsigned sw, sh;
    sw = (cur_sw == 0) ? 64'd1 : 64'(cur_sw);
    sh = (cur_sh == 0) ? 64'd1 : 64'(cur_sh);
    lim_r = int'(eff_dim(cur_gr)) - 1;
    lim_c = int'(eff_dim(cur_gc)) - 1;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: send_word(load_word($urandom_range(0, NBANDS - 1),
                                  $urandom_range(0, lim_r), $urandom_range(0, lim_c),
                                  rand_coef(), rand_coef(), rand_coef()));
        2: send_word(load_word($urandom_range(0, NBANDS - 1), $urandom_range(0, GDIM - 1),
                               $urandom_range(0, GDIM - 1),
                               rand_coef(), rand_coef(), rand_coef()));
        3: send_query(query_word($urandom_range(0, NBANDS - 1), $urandom, $urandom));
        default: begin
          px = (cur_ox + $urandom_range(0, int'(sw - 1))) & 16'hFFFF;
          py = (cur_oy + $urandom_range(0, int'(sh - 1))) & 16'hFFFF;
          send_query(query_word($urandom_range(0, NBANDS - 1), px, py));
        end
      endcase
    end
  endtask

  // Result side: ready drops in random bursts, with calm stretches between
  // and none at all once the run is in its final part.
  int stall_left = 0;
  int calm_left = 0;
  always @(posedge clk) begin
    if (rst || quiet) begin
      result_ch.ready <= !rst;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_ch.ready <= (stall_left == 1);
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      result_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      calm_left <= $urandom_range(20, 80);
      result_ch.ready <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 12);
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // Every result word is matched against the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (coef_due.size() == 0) begin
        $display("%0t: unexpected result word a=%h b=%h c=%h outside=%b", $time,
                 result_ch.data.out_a, result_ch.data.out_b, result_ch.data.out_c,
                 result_ch.data.outside);
        errors++;
      end else begin
        exp_w = coef_due.pop_front();
        if (result_ch.data.out_a !== exp_w.out_a) begin
          $display("%0t: out_a expected %h actual %h", $time, exp_w.out_a,
                   result_ch.data.out_a);
          errors++;
        end
        if (result_ch.data.out_b !== exp_w.out_b) begin
          $display("%0t: out_b expected %h actual %h", $time, exp_w.out_b,
                   result_ch.data.out_b);
          errors++;
        end
        if (result_ch.data.out_c !== exp_w.out_c) begin
          $display("%0t: out_c expected %h actual %h", $time, exp_w.out_c,
                   result_ch.data.out_c);
          errors++;
        end
        if (result_ch.data.outside !== exp_w.outside) begin
          $display("%0t: outside expected %b actual %b", $time, exp_w.outside,
                   result_ch.data.outside);
          errors++;
        end
      end
    end
  end

  // Watchdog: a correct block never goes this long with no word moving.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    grid_cfg_t phases [$];
    grid_cfg_t g;
    out_word_t off_grid;
    in_word_t n;

    item_ch.valid = 1'b0;
    item_ch.data = '0;
    result_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ORIGIN_X;
    cfg_data = '0;
    cur_ox = 0; cur_oy = 0;
    cur_sw = 1; cur_sh = 1;
    cur_gc = 2; cur_gr = 2;
    off_grid = '{out_a: 0, out_b: 0, out_c: 0, outside: 1'b1};

    // Directed part, at the reset setting: a 2 x 2 grid over a single pixel at
    // the image origin, so only point (0, 0) is inside and it maps exactly onto
    // the upper-left node.
    n = load_word(0, 0, 0, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
    dir_tab.push_back('{n, 1'b0, '0});
    dir_tab.push_back('{load_word(0, 0, 1, -32'sd1, 32'sd1, 32'sh12345678), 1'b0, '0});
    dir_tab.push_back('{load_word(0, 1, 0, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1), 1'b0, '0});
    dir_tab.push_back('{load_word(0, 1, 1, 32'sh00010000, -32'sh00010000, 32'sh0), 1'b0, '0});
    dir_tab.push_back('{query_word(0, 0, 0), 1'b1,
                        '{out_a: 32'sh7FFFFFFF, out_b: 32'sh80000000, out_c: 0, outside: 0}});
    // Points one past the span, and the far corner of the image, are outside.
    dir_tab.push_back('{query_word(0, 1, 0), 1'b1, off_grid});
    dir_tab.push_back('{query_word(0, 0, 1), 1'b1, off_grid});
    dir_tab.push_back('{query_word(0, 65535, 65535), 1'b1, off_grid});
    // The last band and the far corner node of the store.
    dir_tab.push_back('{load_word(7, 31, 31, 32'sh80000000, 32'sh7FFFFFFF, -32'sd1), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 31, 0, 32'sh1, 32'sh2, 32'sh3), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 0, 31, -32'sd5, 32'sh0, 32'sh7FFFFFFF), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 0, 0, -32'sd1, 32'sh40000000, 32'sh80000001), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 0, 1, 32'sh0, 32'sh0, 32'sh0), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 1, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF), 1'b0, '0});
    dir_tab.push_back('{load_word(7, 1, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000), 1'b0, '0});
    dir_tab.push_back('{query_word(7, 0, 0), 1'b1,
                        '{out_a: -32'sd1, out_b: 32'sh40000000, out_c: 32'sh80000001, outside: 0}});
    // An outside query on a band never loaded reads no node.
    dir_tab.push_back('{query_word(3, 5, 5), 1'b1, off_grid});
    dir_tab.push_back('{query_word(7, 65535, 0), 1'b1, off_grid});
    // A node rewritten just before a query of it must be seen by that query.
    dir_tab.push_back('{load_word(0, 0, 0, 32'sh00000001, 32'sh0, -32'sd2), 1'b0, '0});
    dir_tab.push_back('{query_word(0, 0, 0), 1'b0, '0});

    // Register settings: both extremes of every register, a zero span and grid
    // sizes below two and above the store's size, then random ones.
    phases.push_back('{16'd0, 16'd0, 17'h10000, 17'h10000, 6'd32, 6'd32});
    phases.push_back('{16'hFFFF, 16'hFFFF, 17'd1, 17'd1, 6'd2, 6'd2});
    phases.push_back('{16'd100, 16'd200, 17'd37, 17'd50, 6'd5, 6'd3});
    phases.push_back('{16'd7, 16'd3, 17'd0, 17'd0, 6'd0, 6'd1});
    phases.push_back('{16'd1000, 16'd30000, 17'd300, 17'd20000, 6'd63, 6'd33});
    repeat (3) begin
      g.ox = 16'($urandom_range(0, 4000));
      g.oy = 16'($urandom);
      g.sw = 17'($urandom_range(1, 3000));
      g.sh = 17'($urandom_range(1, 65536));
      g.gc = 6'($urandom_range(2, 8));
      g.gr = 6'($urandom_range(2, 32));
      phases.push_back(g);
    end
    phases.push_back('{16'd10, 16'd20, 17'd1000, 17'd64, 6'd4, 6'd6});

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);

    // Queries also pull in loads of unwritten neighbours.
    foreach (phases[i]) begin
      write_grid_cfg(phases[i]);
      if (i == phases.size() - 1) quiet = 1'b1;
      run_phase(90);
    end

    item_ch.valid <= 1'b0;
    while (coef_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> grid_coefficient_bilinear_interp.f
hw/rtl/gcbi_pkg.sv
hw/rtl/gcbi_if.sv
hw/rtl/gcbi_map.sv
hw/rtl/gcbi_bank.sv
hw/rtl/gcbi_lerp.sv
hw/rtl/grid_coefficient_bilinear_interp.sv
dv/testbench.sv
